[design/crc16fr_pkg.sv]
// Shared types, codes and constants of the CRC-16 frame receiver.
// Depends on nothing; every other design file refers to it by scoped names.
package crc16fr_pkg;

	// Largest data length a mode 3 frame may announce
	localparam logic [7:0] MAX_DATA = 8'd64;

	// Added to the announced data length to give the byte count at which the low CRC byte closes a frame
	localparam logic [8:0] LEN_EXTRA = 9'd5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Silence counter saturates here
	localparam logic [7:0] SILENCE_CAP = 8'd250;

	// Mode 1 frame size in bytes
	localparam logic [7:0] SUM_FRAME_LEN = 8'd4;

	// Protocol modes (mode 0 and mode 2 ignore bytes)
	localparam logic [1:0] MODE_SUM = 2'd1;
	localparam logic [1:0] MODE_CRC = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_PROTOCOL_MODE = 2'd0;
	localparam logic [1:0] REG_HEADER_BYTE   = 2'd1;
	localparam logic [1:0] REG_SILENCE_LIMIT = 2'd2;

	// Configuration reset values
	localparam logic [1:0] RST_PROTOCOL_MODE = 2'd3;
	localparam logic [7:0] RST_HEADER_BYTE   = 8'd0;
	localparam logic [7:0] RST_SILENCE_LIMIT = 8'd25;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_BYTE    = 3'd1,
		KIND_GOOD    = 3'd2,
		KIND_BAD     = 3'd3,
		KIND_LENERR  = 3'd4,
		KIND_TIMEOUT = 3'd5
	} kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [31:0] bad_check_count;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] protocol_mode;
		logic [7:0] header_byte;
		logic [7:0] silence_limit;
	} cfg_t;

	// One byte through the reflected CRC-16/MODBUS shift register
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b_in);
		logic [15:0] crc;
		logic [7:0]  b;
		logic        mix;
		crc = crc_in;
		b   = b_in;
		for (int i = 0; i < 8; i++) begin
			mix = crc[0] ^ b[0];
			crc = {1'b0, crc[15:1]};
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			b = {1'b0, b[7:1]};
		end
		return crc;
	endfunction

endpackage

[design/crc16_frame_receiver_top.sv]
// CRC-16 frame receiver, top level: input register, framing logic, result register.
// An accepted beat is held in the input register, and its result is registered in the result register.
// Throughput: one beat per cycle unless a full result register is held by out_stall.
// Reset: clears valids and framing state, loads register defaults; no clearing pass.
module crc16_frame_receiver_top #(
	parameter logic [7:0] MAX_DATA = crc16fr_pkg::MAX_DATA
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  crc16fr_pkg::in_beat_t   in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output crc16fr_pkg::out_beat_t  out_data,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [7:0]              cfg_data
);

	crc16fr_pkg::cfg_t      cfg;
	crc16fr_pkg::in_beat_t  item_s1;
	logic                   valid_s1;
	crc16fr_pkg::out_beat_t result;
	crc16fr_pkg::out_beat_t result_s2;
	logic                   valid_s2;
	logic                   advance;
	logic                   step;

	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	crc16fr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crc16fr_frame #(
		.MAX_DATA (MAX_DATA)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Hold the input beat until the framing logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Result register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Input side stalls only with a beat waiting behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	// A beat held in the input register reaches the result register once drained
	a_beat_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("beat lost between stages");

endmodule

[design/crc16fr_cfg.sv]
// Configuration register file of the CRC-16 frame receiver.
// Uses crc16fr_pkg for register indexes, reset values and cfg_t.
module crc16fr_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output crc16fr_pkg::cfg_t   cfg
);

	crc16fr_pkg::cfg_t cfg_q;

	// Write one register; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol_mode <= crc16fr_pkg::RST_PROTOCOL_MODE;
			cfg_q.header_byte   <= crc16fr_pkg::RST_HEADER_BYTE;
			cfg_q.silence_limit <= crc16fr_pkg::RST_SILENCE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				crc16fr_pkg::REG_PROTOCOL_MODE: cfg_q.protocol_mode <= cfg_data[1:0];
				crc16fr_pkg::REG_HEADER_BYTE:   cfg_q.header_byte   <= cfg_data;
				crc16fr_pkg::REG_SILENCE_LIMIT: cfg_q.silence_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/crc16fr_frame.sv]
// Framing state and per-beat decode of the CRC-16 frame receiver.
// Uses crc16fr_pkg for types, codes and the CRC byte update.
module crc16fr_frame #(
	parameter logic [7:0] MAX_DATA = crc16fr_pkg::MAX_DATA
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  crc16fr_pkg::in_beat_t   item,
	input  crc16fr_pkg::cfg_t       cfg,
	output crc16fr_pkg::out_beat_t  result
);

	logic        hunting_q, hunting_n;
	logic [7:0]  count_q, count_n;
	logic [8:0]  length_q, length_n;
	logic [15:0] check_q, check_n;
	logic [7:0]  prev_q, prev_n;
	logic [7:0]  silence_q, silence_n;
	logic [31:0] bad_q, bad_n;

	crc16fr_pkg::kind_t kind;
	logic [7:0]  idx;
	logic [7:0]  b;
	logic [7:0]  count_inc;
	logic [15:0] sum_base;
	logic [8:0]  len_eff;
	logic [7:0]  tick_inc;

	assign b = item.rx_byte;

	// Work out the next state and the result of the beat at the input register
	always_comb begin
		hunting_n = hunting_q;
		count_n   = count_q;
		length_n  = length_q;
		check_n   = check_q;
		prev_n    = prev_q;
		silence_n = silence_q;
		bad_n     = bad_q;
		kind      = crc16fr_pkg::KIND_NONE;
		idx       = '0;
		count_inc = count_q + 8'd1;
		sum_base  = (count_inc == 8'd1) ? 16'd0 : check_q;
		len_eff   = (count_q == 8'd1) ? ({1'b0, b} + crc16fr_pkg::LEN_EXTRA) : length_q;
		tick_inc  = (silence_q < crc16fr_pkg::SILENCE_CAP) ? (silence_q + 8'd1) : silence_q;

		if (item.func) begin
			// Timer tick: count silence only while a frame is open
			if (!hunting_q) begin
				silence_n = tick_inc;
				if (tick_inc == cfg.silence_limit) begin
					hunting_n = 1'b1;
					kind      = crc16fr_pkg::KIND_TIMEOUT;
				end
			end
		end else begin
			silence_n = '0;
			case (cfg.protocol_mode)
				crc16fr_pkg::MODE_SUM: begin
					idx = count_q;
					if (count_inc < crc16fr_pkg::SUM_FRAME_LEN) begin
						count_n = count_inc;
						check_n = sum_base + {8'd0, b};
						kind    = crc16fr_pkg::KIND_BYTE;
					end else begin
						count_n = '0;
						check_n = '0;
						if (sum_base[7:0] == b) begin
							kind = crc16fr_pkg::KIND_GOOD;
						end else begin
							kind  = crc16fr_pkg::KIND_BAD;
							bad_n = bad_q + 32'd1;
						end
					end
				end
				crc16fr_pkg::MODE_CRC: begin
					if (hunting_q) begin
						// Hunt for the header and seed the CRC with it
						if (b == cfg.header_byte) begin
							hunting_n = 1'b0;
							count_n   = '0;
							length_n  = {1'b0, MAX_DATA} + crc16fr_pkg::LEN_EXTRA;
							check_n   = crc16fr_pkg::crc_feed(crc16fr_pkg::CRC_INIT, b);
						end
					end else if (count_q == 8'd1 && b > MAX_DATA) begin
						// Length too large: abandon the frame
						idx       = count_q;
						hunting_n = 1'b1;
						kind      = crc16fr_pkg::KIND_LENERR;
					end else begin
						idx      = count_q;
						kind     = crc16fr_pkg::KIND_BYTE;
						length_n = len_eff;
						if (({2'b00, count_q} + 10'd2) <= {1'b0, len_eff}) begin
							check_n = crc16fr_pkg::crc_feed(check_q, b);
						end else if ({1'b0, count_q} >= len_eff) begin
							// Low CRC byte closes the frame
							hunting_n = 1'b1;
							if ({prev_q, b} == check_q) begin
								kind = crc16fr_pkg::KIND_GOOD;
							end else begin
								kind  = crc16fr_pkg::KIND_BAD;
								bad_n = bad_q + 32'd1;
							end
						end
						prev_n = b;
						if (!hunting_n) begin
							count_n = count_inc;
						end
					end
				end
				default: ;
			endcase
		end

		result.kind            = kind;
		result.data_byte       = (kind == crc16fr_pkg::KIND_NONE ||
		                          kind == crc16fr_pkg::KIND_TIMEOUT) ? 8'd0 : b;
		result.byte_index      = idx;
		result.bad_check_count = bad_n;
	end

	// Advance the framing state once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			count_q   <= '0;
			length_q  <= '0;
			check_q   <= '0;
			prev_q    <= '0;
			silence_q <= '0;
			bad_q     <= '0;
		end else if (step) begin
			hunting_q <= hunting_n;
			count_q   <= count_n;
			length_q  <= length_n;
			check_q   <= check_n;
			prev_q    <= prev_n;
			silence_q <= silence_n;
			bad_q     <= bad_n;
		end
	end

	// The bad-frame counter moves only on a beat, and by one at most
	a_bad_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(bad_q))
		else $error("bad-frame counter changed without a beat");

	a_bad_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (bad_q == $past(bad_q) || bad_q == $past(bad_q) + 32'd1))
		else $error("bad-frame counter jumped");

	// A frame verdict comes only from a received byte
	a_verdict_byte: assert property (@(posedge clk) disable iff (!arst_n)
		step && (result.kind == crc16fr_pkg::KIND_GOOD ||
		         result.kind == crc16fr_pkg::KIND_BAD) |-> !item.func)
		else $error("frame verdict on a timer tick");

	// A timeout leaves the receiver hunting
	a_timeout_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.kind == crc16fr_pkg::KIND_TIMEOUT |=> hunting_q)
		else $error("timeout did not abandon the frame");

endmodule
